// ===== hw/rtl/sfd_pkg.sv =====
// Package for the SBUS frame decoder: state encoding, frame layout and scaling constants.
// Depends on nothing; imported by sbus_frame_decoder_unit, sbus_pulse_checker and tb.
package sfd_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN_RD  = 4'b0010,
        ST_SCAN_CHK = 4'b0100,
        ST_UNPACK   = 4'b1000
    } sfd_state_t;

    // Command codes on the op port.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // Frame layout.
    localparam int FRAME_BYTES   = 25;
    localparam int CHANNELS      = 16;
    localparam int CHAN_BITS     = 11;
    localparam int PAYLOAD_BYTES = 22;
    localparam int FLAG_INDEX    = 23;

    localparam logic [7:0] SYNC_HEAD = 8'h0F;
    localparam logic [7:0] SYNC_TAIL = 8'h00;

    // Bit positions within the flag byte.
    localparam int FAILSAFE_BIT = 3;
    localparam int LOST_BIT     = 2;

    // Pulse scaling: floor(raw * 5 / 8) + offset.
    localparam logic [11:0] PULSE_OFFSET = 12'd880;

endpackage

// ===== hw/rtl/sbus_frame_decoder_unit.sv =====
// SBUS frame decoder top level: burst buffer memory, frame search and channel unpacking.
// Depends on sfd_pkg for state encoding and frame constants.
//
// Usage. A command word is taken at a rising edge where start is high and busy is low.
// With op at OP_BYTE the word carries one received byte, which is written into the burst
// buffer in that same edge; busy stays low, so bytes may follow in consecutive cycles.
// When the buffer already holds BURST_DEPTH bytes, the new byte overwrites position zero
// and the buffer restarts from there.
// With op at OP_IDLE the burst is closed. An empty buffer leaves everything untouched;
// fewer than 25 bytes simply empties the buffer. Otherwise busy rises and the buffer is
// searched from position zero for a 25-byte frame opening with 0x0F and closing with 0x00.
// Each candidate position goes through ST_SCAN_RD, where the two sync bytes are read from
// the memory's two read ports, then ST_SCAN_CHK, which compares them on the following
// cycle. A search that fails tries fill-24 positions and produces no results. On a hit,
// the 22 payload bytes are streamed out of the memory one per cycle, giving sixteen
// results on the strobe port, channel 0 first, the last one marked.
// Each result is present for exactly one cycle; the receiver cannot hold it off.
// The buffer is always emptied when the search ends. The final result appears in the
// same cycle as busy falls, so a new command may already be taken alongside it.
// Reset clears the fill count and the sequencer; the buffer memory itself is not cleared,
// as only positions written since the last reset or wrap are ever read.
module sbus_frame_decoder_unit
    import sfd_pkg::*;
#(
    parameter int BURST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        strobe,
    output logic [3:0]  channel,
    output logic [11:0] pulse_value,
    output logic        failsafe,
    output logic        frame_lost,
    output logic        last
);

    localparam int AW = $clog2(BURST_DEPTH);
    localparam int CW = $clog2(BURST_DEPTH + 1);
    localparam int KW = $clog2(PAYLOAD_BYTES + 1);
    localparam int ACC_W = CHAN_BITS + 7;
    localparam int NB_W = $clog2(ACC_W + 1);

    // Burst buffer, two synchronous read ports.
    logic [7:0]    mem [BURST_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [7:0]    rd_a_reg;
    logic [7:0]    rd_b_reg;

    sfd_state_t       state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [NB_W-1:0]  nbits_reg, nbits_next;
    logic [3:0]       ch_reg, ch_next;

    logic             strobe_reg, strobe_next;
    logic [3:0]       channel_reg;
    logic [11:0]      pulse_reg;
    logic             failsafe_reg;
    logic             lost_reg;
    logic             last_reg;

    logic             accept;
    logic             full;
    logic [ACC_W-1:0] merged;
    logic [NB_W-1:0]  merged_nb;
    logic [CHAN_BITS-1:0] raw;
    logic [CHAN_BITS+2:0] raw_x5;
    logic [11:0]      pulse_calc;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (fill_reg == CW'(BURST_DEPTH));

    // Byte writes go in at the fill position, wrapping to zero when the buffer is full.
    assign mem_we    = accept && (op == OP_BYTE);
    assign mem_waddr = full ? '0 : fill_reg[AW-1:0];

    // Read addresses: sync head and tail while searching, payload and flags while unpacking.
    always_comb
    begin
        if (state_reg == ST_UNPACK)
        begin
            addr_a = pos_reg + AW'(k_reg) + AW'(1);
            addr_b = pos_reg + AW'(FLAG_INDEX);
        end
        else
        begin
            addr_a = pos_reg;
            addr_b = pos_reg + AW'(FRAME_BYTES - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= rx_byte;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Bit stream assembly: the returning payload byte lands above the bits still held.
    assign merged    = acc_reg | (ACC_W'(rd_a_reg) << nbits_reg);
    assign merged_nb = nbits_reg + NB_W'(8);
    assign raw       = merged[CHAN_BITS-1:0];
    assign raw_x5    = {raw, 2'b00} + (CHAN_BITS+3)'(raw);
    assign pulse_calc = 12'(raw_x5 >> 3) + PULSE_OFFSET;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        nbits_next  = nbits_reg;
        ch_next     = ch_reg;
        strobe_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_BYTE)
                    begin
                        fill_next = full ? CW'(1) : fill_reg + CW'(1);
                    end
                    else if (fill_reg < CW'(FRAME_BYTES))
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (rd_a_reg == SYNC_HEAD && rd_b_reg == SYNC_TAIL)
                begin
                    k_next     = '0;
                    acc_next   = '0;
                    nbits_next = '0;
                    ch_next    = '0;
                    state_next = ST_UNPACK;
                end
                else if ((CW'(pos_reg) + CW'(FRAME_BYTES)) < fill_reg)
                begin
                    pos_next   = pos_reg + AW'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_UNPACK:
            begin
                if (k_reg < KW'(PAYLOAD_BYTES))
                begin
                    k_next = k_reg + KW'(1);
                end
                // Data for payload byte k-1 is back from the memory whenever k is non-zero.
                if (k_reg != '0)
                begin
                    if (merged_nb >= NB_W'(CHAN_BITS))
                    begin
                        strobe_next = 1'b1;
                        acc_next    = merged >> CHAN_BITS;
                        nbits_next  = merged_nb - NB_W'(CHAN_BITS);
                        ch_next     = ch_reg + 4'd1;
                        if (ch_reg == 4'(CHANNELS - 1))
                        begin
                            fill_next  = '0;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        acc_next   = merged;
                        nbits_next = merged_nb;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        nbits_reg <= nbits_next;
        ch_reg    <= ch_next;
        if (strobe_next)
        begin
            channel_reg  <= ch_reg;
            pulse_reg    <= pulse_calc;
            failsafe_reg <= rd_b_reg[FAILSAFE_BIT];
            lost_reg     <= rd_b_reg[LOST_BIT];
            last_reg     <= (ch_reg == 4'(CHANNELS - 1));
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign channel     = channel_reg;
    assign pulse_value = pulse_reg;
    assign failsafe    = failsafe_reg;
    assign frame_lost  = lost_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // A result only ever follows a cycle of unpacking.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without preceding decode activity");

    // The end-of-frame mark sits on channel fifteen only.
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (channel == 4'(CHANNELS - 1)))
        else $error("last mark on wrong channel");

    // Once the final channel is out, the sequencer is idle and the buffer empty.
    a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (!busy && fill_reg == '0))
        else $error("decoder still busy after final channel");

    // Fill count never runs past the buffer depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(BURST_DEPTH))
        else $error("fill count beyond buffer depth");

    // Channels within a frame come out in ascending order; checked where two results are back to back.
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && $past(strobe) && channel != '0) |-> (channel == $past(channel) + 4'd1))
        else $error("channel results out of order");
`endif

endmodule

// ===== test/sbus_pulse_checker.sv =====
// Checker for the SBUS frame decoder: mirrors the burst buffer, predicts the channel pulses
// and compares every strobed result against them. Depends on sfd_pkg for frame constants.
module sbus_pulse_checker
    import sfd_pkg::*;
#(
    parameter int BURST_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic        strobe,
    input  logic [3:0]  channel,
    input  logic [11:0] pulse_value,
    input  logic        failsafe,
    input  logic        frame_lost,
    input  logic        last,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [3:0]  channel;
        logic [11:0] pulse_value;
        logic        failsafe;
        logic        frame_lost;
        logic        last;
    } pulse_word_t;

    logic [7:0]  burst_copy [BURST_DEPTH];
    int          fill_copy;
    pulse_word_t expected_pulses [$];
    int          error_count;

    function automatic void compare_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Closes a burst: finds the earliest frame, queues its sixteen pulses, empties the buffer.
    function automatic void decode_burst();
        logic [8*PAYLOAD_BYTES-1:0] payload;
        logic [CHAN_BITS-1:0]       raw;
        logic [14:0]                scaled;
        pulse_word_t                w;
        int                         base;
        base = -1;
        if (fill_copy >= FRAME_BYTES)
        begin
            for (int p = 0; p + FRAME_BYTES <= fill_copy && base < 0; p++)
            begin
                if (burst_copy[p] == SYNC_HEAD && burst_copy[p + FRAME_BYTES - 1] == SYNC_TAIL)
                    base = p;
            end
        end
        if (base >= 0)
        begin
            for (int k = 0; k < PAYLOAD_BYTES; k++)
                payload[8*k +: 8] = burst_copy[base + 1 + k];
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                raw = payload[ch*CHAN_BITS +: CHAN_BITS];
                scaled = ({4'd0, raw} * 15'd5) >> 3;
                w.channel     = 4'(ch);
                w.pulse_value = 12'(scaled) + PULSE_OFFSET;
                w.failsafe    = burst_copy[base + FLAG_INDEX][FAILSAFE_BIT];
                w.frame_lost  = burst_copy[base + FLAG_INDEX][LOST_BIT];
                w.last        = (ch == CHANNELS - 1);
                expected_pulses.push_back(w);
            end
        end
        fill_copy = 0;
    endfunction

    // Results are checked before the word taken at the same edge is predicted, as the
    // final pulse of a frame can coincide with the next command being accepted.
    always @(posedge clk or negedge rst_n)
    begin
        pulse_word_t want;
        if (!rst_n)
        begin
            fill_copy = 0;
            expected_pulses.delete();
            error_count = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_pulses.size() == 0)
                begin
                    $display("%0t: expected no result, got channel %0d pulse %0d", $time,
                             channel, pulse_value);
                    error_count++;
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    compare_field("channel", want.channel, channel);
                    compare_field("pulse_value", want.pulse_value, pulse_value);
                    compare_field("failsafe", want.failsafe, failsafe);
                    compare_field("frame_lost", want.frame_lost, frame_lost);
                    compare_field("last", want.last, last);
                end
            end
            if (start && !busy)
            begin
                if (op == OP_BYTE)
                begin
                    if (fill_copy >= BURST_DEPTH)
                        fill_copy = 0;
                    burst_copy[fill_copy] = rx_byte;
                    fill_copy++;
                end
                else
                    decode_burst();
            end
        end
        pending    = expected_pulses.size();
        mismatches = error_count;
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the SBUS frame decoder: drives bursts of received bytes and idle words.
// Depends on sfd_pkg, sbus_frame_decoder_unit and sbus_pulse_checker.
module tb;
    import sfd_pkg::*;

    localparam int BURST_DEPTH = 64;
    // Random part stops once roughly this many words have been taken.
    localparam int ITEM_TARGET = 470;
    // Cycle limit for the whole run, well above the worst case for ITEM_TARGET words.
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        BURST_FRAME,
        BURST_BROKEN,
        BURST_NOISE,
        BURST_WRAP
    } burst_kind_t;

    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM,
        FILL_MIXED
    } payload_fill_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [7:0]  rx_byte;
    logic        strobe;
    logic [3:0]  channel;
    logic [11:0] pulse_value;
    logic        failsafe;
    logic        frame_lost;
    logic        last;
    int          mismatches;
    int          pending;

    // Bytes of the burst being assembled, sent in order and then closed by an idle word.
    logic [7:0]  burst_bytes [$];
    int          items_sent;
    // When set, words follow each other with no gap at all.
    bit          no_gaps;
    int          cycles;

    sbus_frame_decoder_unit #(
        .BURST_DEPTH (BURST_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .rx_byte     (rx_byte),
        .strobe      (strobe),
        .channel     (channel),
        .pulse_value (pulse_value),
        .failsafe    (failsafe),
        .frame_lost  (frame_lost),
        .last        (last)
    );

    sbus_pulse_checker #(
        .BURST_DEPTH (BURST_DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .rx_byte     (rx_byte),
        .strobe      (strobe),
        .channel     (channel),
        .pulse_value (pulse_value),
        .failsafe    (failsafe),
        .frame_lost  (frame_lost),
        .last        (last),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guards against a hung handshake: the run is abandoned once the cycle limit is hit.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Gap length after a word. Most gaps are nil or short, a few are long, so that pauses
    // land on every phase of a search and of the unpacking.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Presents one word at the falling edge and holds it until a rising edge sees busy low.
    // Start is only lowered at a later falling edge, and only if a gap follows, so that it
    // never gets two assignments in one time step.
    task automatic put_word(input logic word_op, input logic [7:0] word_byte);
        int gap;
        @(negedge clk);
        start   <= 1'b1;
        op      <= word_op;
        rx_byte <= word_byte;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Holds the sender back until every predicted pulse has been seen. Start is dropped
    // first so that the word already taken is not offered again while waiting, and the
    // count is only read once the checker has seen the last accepted word.
    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] payload_byte(payload_fill_t fill);
        payload_fill_t pick;
        pick = (fill == FILL_MIXED) ? payload_fill_t'($urandom_range(0, 2)) : fill;
        case (pick)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void append_junk(int n);
        for (int k = 0; k < n; k++)
            burst_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Appends a frame. A broken head or tail replaces the sync byte with something else;
    // a cut drops that many bytes from the end of the frame.
    function automatic void append_frame(payload_fill_t fill, logic [7:0] flags,
                                         bit bad_head, bit bad_tail, int cut);
        logic [7:0] head;
        head = 8'($urandom_range(0, 255));
        if (head == SYNC_HEAD)
            head = head ^ 8'h80;
        burst_bytes.push_back(bad_head ? head : SYNC_HEAD);
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            burst_bytes.push_back(payload_byte(fill));
        burst_bytes.push_back(flags);
        burst_bytes.push_back(bad_tail ? 8'($urandom_range(1, 255)) : SYNC_TAIL);
        for (int k = 0; k < cut; k++)
            void'(burst_bytes.pop_back());
    endfunction

    // Sends the assembled bytes and closes the burst with an idle word, whose byte field
    // is random as the block ignores it.
    task automatic send_burst();
        foreach (burst_bytes[k])
            put_word(OP_BYTE, burst_bytes[k]);
        put_word(OP_IDLE, 8'($urandom_range(0, 255)));
        burst_bytes.delete();
    endtask

    initial
    begin
        burst_kind_t   kind;
        payload_fill_t fill;
        logic [7:0]    flags;
        int            iter;
        int            r;

        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_BYTE;
        rx_byte    = 8'h00;
        items_sent = 0;
        no_gaps    = 1'b1;
        iter       = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. An idle word on an empty buffer must do nothing at all.
        put_word(OP_IDLE, 8'hFF);
        // A burst shorter than a frame is simply discarded.
        burst_bytes.push_back(SYNC_HEAD);
        burst_bytes.push_back(SYNC_TAIL);
        send_burst();
        // A frame of all-ones payload gives the top pulse on every channel, with both
        // the failsafe and frame-lost flags raised.
        no_gaps = 1'b0;
        append_frame(FILL_ONES, 8'h0C, 1'b0, 1'b0, 0);
        send_burst();

        // Random part. Most bursts carry a well-formed frame with random content, often
        // behind leading junk; the rest are broken frames, noise and bursts long enough
        // to wrap the buffer. The first two bursts force a wrap and a failed search.
        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (iter % 8 == 3)
                wait_for_drain();
            r = $urandom_range(0, 99);
            if (iter == 0)
                kind = BURST_WRAP;
            else if (iter == 1)
                kind = BURST_BROKEN;
            else if (r < 60)
                kind = BURST_FRAME;
            else if (r < 80)
                kind = BURST_BROKEN;
            else if (r < 95)
                kind = BURST_NOISE;
            else
                kind = BURST_WRAP;
            fill  = payload_fill_t'($urandom_range(0, 3));
            flags = 8'($urandom_range(0, 255));

            case (kind)
                BURST_FRAME:
                begin
                    if ($urandom_range(0, 2) == 0)
                        append_junk($urandom_range(1, BURST_DEPTH - FRAME_BYTES));
                    append_frame(fill, flags, 1'b0, 1'b0, 0);
                    // Now and then the burst is padded to exactly a full buffer.
                    if ($urandom_range(0, 4) == 0)
                        append_junk(BURST_DEPTH - burst_bytes.size());
                    else
                        append_junk($urandom_range(0, 3));
                end
                BURST_BROKEN:
                begin
                    append_junk($urandom_range(0, 4));
                    case ($urandom_range(0, 2))
                        0:       append_frame(fill, flags, 1'b1, 1'b0, 0);
                        1:       append_frame(fill, flags, 1'b0, 1'b1, 0);
                        default: append_frame(fill, flags, 1'b0, 1'b0, $urandom_range(1, 24));
                    endcase
                end
                BURST_NOISE:
                    append_junk($urandom_range(0, 40));
                default:
                begin
                    // The first frame is overrun once the buffer wraps; whatever follows
                    // the wrap is all that the search may see.
                    append_frame(fill, flags, 1'b0, 1'b0, 0);
                    append_junk(BURST_DEPTH - FRAME_BYTES + $urandom_range(0, 12));
                    if ($urandom_range(0, 1) == 0)
                        append_frame(payload_fill_t'($urandom_range(0, 3)),
                                     8'($urandom_range(0, 255)), 1'b0, 1'b0, 0);
                    else
                        append_junk($urandom_range(0, 30));
                end
            endcase
            send_burst();
            // A stray idle word lands on an already emptied buffer.
            if ($urandom_range(0, 9) == 0)
                put_word(OP_IDLE, 8'($urandom_range(0, 255)));
            iter++;
        end

        @(negedge clk);
        start <= 1'b0;
        wait_for_drain();
        // Allow time for any stray pulse to show up after the last expected one.
        repeat (50) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sbus_frame_decoder_unit.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sbus_frame_decoder_unit.sv
test/sbus_pulse_checker.sv
test/tb.sv
